FILE: hw/rtl/btsb_pkg.sv
package btsb_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TEX_ID_BITS_DEF = 32;

  // Fixed field widths of the channels.
  localparam int REQ_W = 2;
  localparam int TEX_W_MAX = 32;
  localparam int SLOT_IDX_W = 4;
  localparam int QUAD_W = 16;
  localparam int CALL_W = 16;
  localparam int TOTAL_W = 32;
  localparam int USABLE_W = 5;
  localparam int LIMIT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_USABLE_SLOTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_LIMIT = 1'd1;

  localparam logic [USABLE_W-1:0] USABLE_RESET = 5'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END = 2'd2;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

endpackage

FILE: hw/rtl/btsb_slot_table.sv
module btsb_slot_table #(
  parameter int SLOT_COUNT = btsb_pkg::SLOT_COUNT_DEF,
  parameter int TEX_W = btsb_pkg::TEX_W_MAX,
  localparam int SLOT_BITS = $clog2(SLOT_COUNT)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  logic [TEX_W-1:0]     wr_data,
  input  logic [SLOT_BITS-1:0] rd_addr,
  input  logic [TEX_W-1:0]     cmp_data,
  output logic [TEX_W-1:0]     rd_data,
  output logic                 hit
);
  import btsb_pkg::*;

  logic [TEX_W-1:0] slot_mem_r [SLOT_COUNT];
  logic [TEX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    // Slot 0 is never written and always reads as the white texture.
    if (rd_addr == '0) begin
      rd_data_r <= '0;
    end else begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign hit = (rd_data_r == cmp_data);

endmodule

FILE: hw/rtl/batch_texture_slot_binder_core.sv
// Texture slot binder for a quad batcher.
// Input items are requests: begin scene, draw quad, end scene. An item is taken at a
// clock edge with start high and busy low; busy stays high while the item is worked on.
// Results leave on the out_ ports for one cycle each, marked by out_valid; out_last flags
// the final result of an item. The receiver cannot stall, so results are never held.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must do
// so only while the block is idle, since the block itself does not enforce it.
// Begin scene and ignored requests give no result and leave the block idle. A draw
// quad searches the bound slots through one shared comparator on the slot table,
// one slot per cycle, until a hit or a miss. A flush lists every bound slot, one per
// cycle, since the table has one read port; a flush forced by a new id then takes
// the slot in the alloc state. An end scene with quads in the batch flushes it. Every
// result is registered and leaves the out_ ports in the cycle after the one that made it.
// Reset (synchronous, rst_n low) closes the scene, empties the batch, clears the counters
// and restores usable_slots to 16 and batch_quad_limit to 10000.
module batch_texture_slot_binder_core #(
  parameter int SLOT_COUNT = btsb_pkg::SLOT_COUNT_DEF,
  parameter int TEXTURE_ID_BITS = btsb_pkg::TEX_ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [btsb_pkg::REQ_W-1:0]        in_req_type,
  input  logic [btsb_pkg::TEX_W_MAX-1:0]    in_texture_id,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic [btsb_pkg::SLOT_IDX_W-1:0]   out_slot_index,
  output logic [btsb_pkg::TEX_W_MAX-1:0]    out_bound_texture,
  output logic [btsb_pkg::QUAD_W-1:0]       out_batch_quads,
  output logic [btsb_pkg::CALL_W-1:0]       out_draw_calls,
  output logic [btsb_pkg::TOTAL_W-1:0]      out_scene_quads,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [btsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btsb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import btsb_pkg::*;

  localparam int TEX_W = (TEXTURE_ID_BITS < TEX_W_MAX) ? TEXTURE_ID_BITS : TEX_W_MAX;
  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_ALLOC = 2'd3;

  // What follows a flush.
  localparam logic [1:0] CONT_END = 2'd0;
  localparam logic [1:0] CONT_SEARCH = 2'd1;
  localparam logic [1:0] CONT_ALLOC = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           cont_r, cont_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     slots_used_r, slots_used_nxt;
  logic [QUAD_W-1:0]    quads_r, quads_nxt;
  logic [CALL_W-1:0]    flush_count_r, flush_count_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 active_r, active_nxt;
  logic [TEX_W-1:0]     tex_r, tex_nxt;
  logic [USABLE_W-1:0]  usable_r;
  logic [LIMIT_W-1:0]   limit_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [SLOT_IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [TEX_W_MAX-1:0] out_tex_r, out_tex_nxt;
  logic [QUAD_W-1:0]    out_bq_r, out_bq_nxt;
  logic [CALL_W-1:0]    out_calls_r, out_calls_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [CNT_W-1:0]     eff_slots;
  logic                 tbl_we;
  logic [TEX_W-1:0]     rd_data;
  logic                 hit;
  logic                 emit_ans;
  logic                 do_alloc;
  logic                 start_flush;
  logic [1:0]           flush_cont;
  logic [CNT_W-1:0]     ans_slot;
  logic [CNT_W+SLOT_IDX_W-1:0] ans_slot_ext;
  logic [CNT_W+SLOT_IDX_W-1:0] idx_ext;
  logic [TEX_W+TEX_W_MAX-1:0]  tex_ext;
  logic [TEX_W+TEX_W_MAX-1:0]  rd_ext;
  logic [QUAD_W-1:0]    quads_inc;
  logic [TOTAL_W-1:0]   total_inc;

  // The table read is registered, so it is addressed with the next index and its data
  // lines up with idx_r in the following cycle.
  btsb_slot_table #(
    .SLOT_COUNT(SLOT_COUNT),
    .TEX_W(TEX_W)
  ) u_table (
    .clk(clk),
    .wr_en(tbl_we),
    .wr_addr(slots_used_r[SLOT_BITS-1:0]),
    .wr_data(tex_r),
    .rd_addr(idx_nxt[SLOT_BITS-1:0]),
    .cmp_data(tex_r),
    .rd_data(rd_data),
    .hit(hit)
  );

  always_comb begin
    if (usable_r == '0) begin
      eff_slots = CNT_W'(1);
    end else if (int'(usable_r) > SLOT_COUNT) begin
      eff_slots = CNT_W'(SLOT_COUNT);
    end else begin
      eff_slots = CNT_W'(usable_r);
    end
  end

  assign quads_inc = (quads_r == '1) ? quads_r : quads_r + QUAD_W'(1);
  assign total_inc = (total_r == '1) ? total_r : total_r + TOTAL_W'(1);
  assign tex_ext = {{TEX_W_MAX{1'b0}}, tex_r};
  assign rd_ext = {{TEX_W_MAX{1'b0}}, rd_data};
  assign idx_ext = {{SLOT_IDX_W{1'b0}}, idx_r};
  assign ans_slot_ext = {{SLOT_IDX_W{1'b0}}, ans_slot};

  always_comb begin
    state_nxt = state_r;
    cont_nxt = cont_r;
    idx_nxt = idx_r;
    slots_used_nxt = slots_used_r;
    quads_nxt = quads_r;
    flush_count_nxt = flush_count_r;
    total_nxt = total_r;
    active_nxt = active_r;
    tex_nxt = tex_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt = out_kind_r;
    out_slot_nxt = out_slot_r;
    out_tex_nxt = out_tex_r;
    out_bq_nxt = out_bq_r;
    out_calls_nxt = out_calls_r;
    out_total_nxt = out_total_r;
    out_last_nxt = out_last_r;
    tbl_we = 1'b0;
    emit_ans = 1'b0;
    do_alloc = 1'b0;
    start_flush = 1'b0;
    flush_cont = CONT_END;
    ans_slot = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tex_nxt = in_texture_id[TEX_W-1:0];
          case (in_req_type)
            REQ_BEGIN: begin
              flush_count_nxt = '0;
              total_nxt = '0;
              quads_nxt = '0;
              slots_used_nxt = CNT_W'(1);
              active_nxt = 1'b1;
            end
            REQ_DRAW: begin
              if (active_r) begin
                if (quads_r >= limit_r && quads_r != '0) begin
                  start_flush = 1'b1;
                  flush_cont = CONT_SEARCH;
                end else begin
                  state_nxt = ST_SEARCH;
                  idx_nxt = CNT_W'(1);
                end
              end
            end
            REQ_END: begin
              if (active_r) begin
                active_nxt = 1'b0;
                if (quads_r != '0) begin
                  start_flush = 1'b1;
                  flush_cont = CONT_END;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (tex_r == '0) begin
          ans_slot = '0;
          emit_ans = 1'b1;
        end else if (idx_r < slots_used_r) begin
          if (hit) begin
            emit_ans = 1'b1;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else if (slots_used_r >= eff_slots && quads_r != '0) begin
          start_flush = 1'b1;
          flush_cont = CONT_ALLOC;
        end else begin
          // An empty batch already has only the white slot bound.
          do_alloc = 1'b1;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt = KIND_FLUSH;
        out_slot_nxt = idx_ext[SLOT_IDX_W-1:0];
        out_tex_nxt = rd_ext[TEX_W_MAX-1:0];
        out_bq_nxt = quads_r;
        out_calls_nxt = flush_count_r;
        out_total_nxt = total_r;
        out_last_nxt = 1'b0;
        if (idx_r == slots_used_r - CNT_W'(1)) begin
          case (cont_r)
            CONT_SEARCH: begin
              quads_nxt = '0;
              slots_used_nxt = CNT_W'(1);
              idx_nxt = CNT_W'(1);
              state_nxt = ST_SEARCH;
            end
            CONT_ALLOC: begin
              quads_nxt = '0;
              slots_used_nxt = CNT_W'(1);
              state_nxt = ST_ALLOC;
            end
            default: begin
              out_last_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_ALLOC: begin
        do_alloc = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_flush) begin
      if (flush_count_r != '1) begin
        flush_count_nxt = flush_count_r + CALL_W'(1);
      end
      idx_nxt = '0;
      cont_nxt = flush_cont;
      state_nxt = ST_FLUSH;
    end

    if (do_alloc) begin
      ans_slot = slots_used_r;
      tbl_we = 1'b1;
      slots_used_nxt = slots_used_r + CNT_W'(1);
      emit_ans = 1'b1;
    end

    if (emit_ans) begin
      quads_nxt = quads_inc;
      total_nxt = total_inc;
      out_valid_nxt = 1'b1;
      out_kind_nxt = KIND_ANSWER;
      out_slot_nxt = ans_slot_ext[SLOT_IDX_W-1:0];
      out_tex_nxt = tex_ext[TEX_W_MAX-1:0];
      out_bq_nxt = quads_inc;
      out_calls_nxt = flush_count_r;
      out_total_nxt = total_inc;
      out_last_nxt = 1'b1;
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cont_r <= CONT_END;
      idx_r <= '0;
      slots_used_r <= CNT_W'(1);
      quads_r <= '0;
      flush_count_r <= '0;
      total_r <= '0;
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cont_r <= cont_nxt;
      idx_r <= idx_nxt;
      slots_used_r <= slots_used_nxt;
      quads_r <= quads_nxt;
      flush_count_r <= flush_count_nxt;
      total_r <= total_nxt;
      active_r <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tex_r <= tex_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_tex_r <= out_tex_nxt;
    out_bq_r <= out_bq_nxt;
    out_calls_r <= out_calls_nxt;
    out_total_r <= out_total_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= USABLE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USABLE_SLOTS: usable_r <= cfg_data[USABLE_W-1:0];
        REG_QUAD_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_slot_index = out_slot_r;
  assign out_bound_texture = out_tex_r;
  assign out_batch_quads = out_bq_r;
  assign out_draw_calls = out_calls_r;
  assign out_scene_quads = out_total_r;
  assign out_last = out_last_r;

endmodule

FILE: tb/batch_texture_slot_binder_core_tb.sv
module batch_texture_slot_binder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btsb_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_IDX_W-1:0] slot;
    logic [TEX_W_MAX-1:0]  tex;
    logic [QUAD_W-1:0]     quads;
    logic [CALL_W-1:0]     calls;
    logic [TOTAL_W-1:0]    scene_total;
    logic                  last;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [TEX_W_MAX-1:0] in_texture_id = '0;
  logic out_valid;
  logic out_kind;
  logic [SLOT_IDX_W-1:0] out_slot_index;
  logic [TEX_W_MAX-1:0] out_bound_texture;
  logic [QUAD_W-1:0] out_batch_quads;
  logic [CALL_W-1:0] out_draw_calls;
  logic [TOTAL_W-1:0] out_scene_quads;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  batch_texture_slot_binder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_texture_id(in_texture_id),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_slot_index(out_slot_index),
    .out_bound_texture(out_bound_texture),
    .out_batch_quads(out_batch_quads),
    .out_draw_calls(out_draw_calls),
    .out_scene_quads(out_scene_quads),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Binder state as the block should hold it.
  logic [TEX_W_MAX-1:0] bound_ids [SLOTS];
  int unsigned slots_taken;
  int unsigned batch_quads;
  int unsigned draw_call_count;
  logic [TOTAL_W-1:0] scene_quad_total;
  bit scene_open;
  logic [USABLE_W-1:0] usable_reg;
  logic [LIMIT_W-1:0] limit_reg;

  slot_result_t pending_results[$];
  slot_result_t head;
  logic [TEX_W_MAX-1:0] tex_pool [6];

  int idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  task automatic push_result(input logic kind, input int unsigned slot,
                             input logic [TEX_W_MAX-1:0] tex, input bit last);
    slot_result_t r;
    r.kind = kind;
    r.slot = slot[SLOT_IDX_W-1:0];
    r.tex = tex;
    r.quads = batch_quads[QUAD_W-1:0];
    r.calls = draw_call_count[CALL_W-1:0];
    r.scene_total = scene_quad_total;
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endtask

  // A flush lists every bound slot, but only when the batch holds quads.
  task automatic flush_batch_listing(input bit closing);
    int unsigned span;
    if (batch_quads != 0) begin
      if (draw_call_count < 16'hFFFF) draw_call_count++;
      span = slots_taken > SLOTS ? SLOTS : slots_taken;
      for (int unsigned i = 0; i < span; i++) begin
        push_result(KIND_FLUSH, i, bound_ids[i], closing && (i == span - 1));
      end
    end
  endtask

  task automatic start_fresh_batch();
    batch_quads = 0;
    slots_taken = 1;
  endtask

  task automatic bind_request(input logic [REQ_W-1:0] req, input logic [TEX_W_MAX-1:0] tex);
    int unsigned slot;
    int unsigned span;
    int unsigned usable_eff;
    bit found;
    slot = 0;
    found = 1'b0;
    case (req)
      REQ_BEGIN: begin
        draw_call_count = 0;
        scene_quad_total = '0;
        start_fresh_batch();
        scene_open = 1'b1;
      end
      REQ_END: begin
        if (scene_open) begin
          flush_batch_listing(1'b1);
          scene_open = 1'b0;
        end
      end
      REQ_DRAW: begin
        if (scene_open) begin
          if (batch_quads >= limit_reg) begin
            flush_batch_listing(1'b0);
            start_fresh_batch();
          end
          if (tex != '0) begin
            span = slots_taken > SLOTS ? SLOTS : slots_taken;
            for (int unsigned i = 1; i < span; i++) begin
              if (!found && bound_ids[i] == tex) begin
                slot = i;
                found = 1'b1;
              end
            end
            if (!found) begin
              usable_eff = (usable_reg == 0) ? 1 : ((usable_reg > SLOTS) ? SLOTS : usable_reg);
              if (slots_taken >= usable_eff) begin
                flush_batch_listing(1'b0);
                start_fresh_batch();
              end
              slot = slots_taken;
              if (slot < SLOTS) bound_ids[slot] = tex;
              slots_taken++;
            end
          end
          if (batch_quads < 16'hFFFF) batch_quads++;
          if (scene_quad_total != '1) scene_quad_total++;
          push_result(KIND_ANSWER, slot, tex, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // Holds start high until the block takes the item, then idles at random.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [TEX_W_MAX-1:0] tex);
    int gap;
    start <= 1'b1;
    in_req_type <= req;
    in_texture_id <= tex;
    do @(posedge clk); while (busy);
    bind_request(req, tex);
    items_sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Begin scene and ignored items give no result, so let the block settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_USABLE_SLOTS) usable_reg = data[USABLE_W-1:0];
    else limit_reg = data[LIMIT_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_ignored_requests();
    send_item(REQ_DRAW, 32'hFFFF_FFFF);
    send_item(REQ_END, 32'h0);
    send_item(REQ_UNUSED, 32'hFFFF_FFFF);
    // An end with an empty batch closes the scene without a flush.
    send_item(REQ_BEGIN, 32'h0);
    send_item(REQ_END, 32'h0);
  endtask

  task automatic test_slot_fill_and_reuse();
    send_item(REQ_BEGIN, 32'h0);
    send_item(REQ_DRAW, 32'h0);
    send_item(REQ_DRAW, 32'hFFFF_FFFF);
    send_item(REQ_DRAW, 32'hFFFF_FFFF);
    for (int k = 0; k < 14; k++) send_item(REQ_DRAW, 32'h1 << k);
    // All sixteen slots are bound now, so a new id flushes the full table first.
    send_item(REQ_DRAW, 32'h8000_0000);
  endtask

  task automatic test_scene_restart();
    // The open batch is dropped without a flush and the statistics restart.
    send_item(REQ_BEGIN, 32'h0);
    send_item(REQ_DRAW, 32'h8000_0000);
    send_item(REQ_END, 32'h0);
  endtask

  task automatic test_random_traffic(input int pct, input logic [USABLE_W-1:0] usable,
                                     input logic [LIMIT_W-1:0] limit, input int count);
    int done_items;
    int r;
    logic [REQ_W-1:0] req;
    logic [TEX_W_MAX-1:0] tex;
    bit counted;
    wait_drained();
    write_reg(REG_USABLE_SLOTS, {11'($urandom), usable});
    write_reg(REG_QUAD_LIMIT, limit);
    foreach (tex_pool[k]) tex_pool[k] = $urandom;
    idle_pct = pct;
    settings_used++;
    done_items = 0;
    while (done_items < count) begin
      r = $urandom_range(99);
      if (!scene_open && $urandom_range(3) != 0) req = REQ_BEGIN;
      else if (r < 5) req = REQ_BEGIN;
      else if (r < 83) req = REQ_DRAW;
      else if (r < 93) req = REQ_END;
      else req = REQ_UNUSED;
      r = $urandom_range(99);
      if (r < 15) tex = '0;
      else if (r < 70) tex = tex_pool[$urandom_range(5)];
      else tex = $urandom;
      counted = (req == REQ_BEGIN) || (scene_open && (req == REQ_DRAW || req == REQ_END));
      send_item(req, tex);
      if (counted) begin
        done_items++;
        if (done_items == count / 2) wait_drained();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] expected_val,
                             input logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected_val, actual_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got slot %0d texture %0h",
                 $time, out_slot_index, out_bound_texture);
        error_count++;
      end else begin
        head = pending_results.pop_front();
        check_field("kind", head.kind, out_kind);
        check_field("slot_index", head.slot, out_slot_index);
        check_field("bound_texture", head.tex, out_bound_texture);
        check_field("batch_quads", head.quads, out_batch_quads);
        check_field("draw_calls", head.calls, out_draw_calls);
        check_field("scene_quads", head.scene_total, out_scene_quads);
        check_field("last", head.last, out_last);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("batch_texture_slot_binder_core_tb: errors");
      $finish;
    end
  end

  initial begin
    foreach (bound_ids[k]) bound_ids[k] = '0;
    slots_taken = 1;
    batch_quads = 0;
    draw_call_count = 0;
    scene_quad_total = '0;
    scene_open = 1'b0;
    usable_reg = USABLE_RESET;
    limit_reg = LIMIT_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_requests();
    test_slot_fill_and_reuse();
    test_scene_restart();

    test_random_traffic(0, 5'd16, 16'd10000, 12);
    test_random_traffic(71, 5'd1, 16'd1, 12);
    test_random_traffic(7, 5'd4, 16'd3, 12);
    test_random_traffic(0, 5'd0, 16'd0, 11);
    test_random_traffic(71, 5'd31, 16'd65535, 12);
    test_random_traffic(0, 5'd2, 16'd5, 11);

    wait_drained();
    $display("sent %0d items and checked %0d results across %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("covering slot reuse, full-table flushes, quad limits and ignored requests");
    if (error_count == 0) begin
      $display("batch_texture_slot_binder_core_tb: clean");
    end else begin
      $display("batch_texture_slot_binder_core_tb: errors");
    end
    $finish;
  end

endmodule
